// ----- design/stkpal_pkg.sv -----
// Shared types and constants for the stack with palindrome check.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package stkpal_pkg;

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE     = 2'd0,
        S_POP_WAIT = 2'd1,
        S_CHK_RD   = 2'd2,
        S_CHK_CMP  = 2'd3
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    push;       // store the pushed word and raise the count
        logic    pop;        // lower the count
        logic    rd_top;     // read the top entry on the second port
        logic    chk_init;   // load the bottom and top pointers
        logic    chk_adv;    // move both pointers one entry inward
        logic    emit;       // load the result registers
        t_status res_status;
        logic    res_pal;
        logic    res_use_rd; // take the popped word from the read port
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic single;
        logic mismatch;
        logic last_pair;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/stack_with_palindrome_check.sv -----
// Top level of the LIFO stack with palindrome check.
// Instantiates stkpal_ctrl and stkpal_dp; depends on stkpal_pkg.
//
// An item is taken when start is high and busy is low; each item gives one
// result, shown for one cycle with o_valid high, and the receiver cannot
// stall it. For a push, any failed operation and a check on a single entry,
// the result appears in the next cycle and busy stays low. A successful
// pop passes through S_POP_WAIT, since the entry memory has a registered
// read. A check on N >= 2 entries reads one pair at a time from the
// memory's two read ports, alternating S_CHK_RD and S_CHK_CMP, and stops
// early at the first mismatch. The fill count reported is the count after
// the operation, low 8 bits.
`default_nettype none

module stack_with_palindrome_check #(
    parameter int DEPTH = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_cmd,
    input  wire logic signed [31:0] i_push_value,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_popped_value,
    output logic                    o_is_palindrome,
    output logic [7:0]              o_fill_count
);
    import stkpal_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Controller.
    stkpal_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_stat   (dp_stat),
        .o_dp_cmd (dp_cmd),
        .o_busy   (busy)
    );

    // Datapath.
    stkpal_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (dp_cmd),
        .i_push_value    (i_push_value),
        .o_stat          (dp_stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_popped_value  (o_popped_value),
        .o_is_palindrome (o_is_palindrome),
        .o_fill_count    (o_fill_count)
    );

    // A result is only ever shown once the block has gone idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // A push always gives its result in the next cycle.
    a_push_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_PUSH) |=> o_valid)
        else $error("push result missing");

    // An overflow is only reported on a full stack.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OVERFLOW) |-> o_fill_count == 8'(DEPTH))
        else $error("overflow reported below full");

    // A palindrome flag only comes with a good check, never with a word.
    a_pal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_palindrome) |-> (o_status == ST_OK && o_popped_value == 32'sd0))
        else $error("palindrome flag with bad status or word");

endmodule

`default_nettype wire

// ----- design/stkpal_ctrl.sv -----
// Controller state machine for the stack with palindrome check.
// Depends on stkpal_pkg for the state, command and status types.
`default_nettype none

module stkpal_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [1:0]           i_cmd,
    input  wire stkpal_pkg::t_dp_stat i_stat,
    output stkpal_pkg::t_dp_cmd       o_dp_cmd,
    output logic                      o_busy
);
    import stkpal_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == CMD_POP && !i_stat.empty) begin
                        n_state = S_POP_WAIT;
                    end else if (i_cmd == CMD_CHECK && !i_stat.empty && !i_stat.single) begin
                        n_state = S_CHK_RD;
                    end
                end
            end
            S_POP_WAIT: n_state = S_IDLE;
            S_CHK_RD:   n_state = S_CHK_CMP;
            S_CHK_CMP: begin
                if (i_stat.mismatch || i_stat.last_pair) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CHK_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: datapath commands and the busy flag.
    always_comb begin
        o_dp_cmd            = '0;
        o_dp_cmd.res_status = ST_OK;
        o_busy              = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_cmd)
                        CMD_PUSH: begin
                            o_dp_cmd.emit = 1'b1;
                            if (i_stat.full) begin
                                o_dp_cmd.res_status = ST_OVERFLOW;
                            end else begin
                                o_dp_cmd.push = 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (i_stat.empty) begin
                                o_dp_cmd.emit       = 1'b1;
                                o_dp_cmd.res_status = ST_UNDERFLOW;
                            end else begin
                                o_dp_cmd.pop    = 1'b1;
                                o_dp_cmd.rd_top = 1'b1;
                            end
                        end
                        CMD_CHECK: begin
                            if (i_stat.empty) begin
                                o_dp_cmd.emit       = 1'b1;
                                o_dp_cmd.res_status = ST_EMPTY;
                            end else if (i_stat.single) begin
                                o_dp_cmd.emit    = 1'b1;
                                o_dp_cmd.res_pal = 1'b1;
                            end else begin
                                o_dp_cmd.chk_init = 1'b1;
                            end
                        end
                        default: begin
                            // Unused command code: no operation, plain result.
                            o_dp_cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_POP_WAIT: begin
                o_dp_cmd.emit       = 1'b1;
                o_dp_cmd.res_use_rd = 1'b1;
            end
            S_CHK_RD: begin
                // The pair is read from memory in this cycle.
            end
            S_CHK_CMP: begin
                if (i_stat.mismatch) begin
                    o_dp_cmd.emit = 1'b1;
                end else if (i_stat.last_pair) begin
                    o_dp_cmd.emit    = 1'b1;
                    o_dp_cmd.res_pal = 1'b1;
                end else begin
                    o_dp_cmd.chk_adv = 1'b1;
                end
            end
            default: begin
                o_dp_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/stkpal_dp.sv -----
// Datapath for the stack with palindrome check: entry memory, fill count,
// check pointers and result registers. Depends on stkpal_pkg.
`default_nettype none

module stkpal_dp #(
    parameter int DEPTH = 128
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire stkpal_pkg::t_dp_cmd i_dp_cmd,
    input  wire logic signed [31:0]  i_push_value,
    output stkpal_pkg::t_dp_stat     o_stat,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic signed [31:0]       o_popped_value,
    output logic                     o_is_palindrome,
    output logic [7:0]               o_fill_count
);
    import stkpal_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rd_a;
    logic [31:0]   r_rd_b;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] count_m1;
    logic [AW-1:0] r_lo;
    logic [AW-1:0] r_hi;
    logic [AW-1:0] addr_b;
    logic [AW:0]   span;
    logic [CW+7:0] fill_ext;

    logic          r_valid;
    t_status       r_status;
    logic [31:0]   r_popped;
    logic          r_pal;
    logic [7:0]    r_fill;

    // Fill count arithmetic.
    assign count_m1 = r_count - 1'b1;

    always_comb begin
        n_count = r_count;
        if (i_dp_cmd.push) begin
            n_count = r_count + 1'b1;
        end else if (i_dp_cmd.pop) begin
            n_count = count_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Entry memory: one write port, two registered read ports.
    assign addr_b = i_dp_cmd.rd_top ? count_m1[AW-1:0] : r_hi;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.push) begin
            r_mem[r_count[AW-1:0]] <= i_push_value;
        end
        r_rd_a <= r_mem[r_lo];
        r_rd_b <= r_mem[addr_b];
    end

    // Check pointers walk inward from the bottom and the top.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.chk_init) begin
            r_lo <= '0;
            r_hi <= count_m1[AW-1:0];
        end else if (i_dp_cmd.chk_adv) begin
            r_lo <= r_lo + 1'b1;
            r_hi <= r_hi - 1'b1;
        end
    end

    // One bit wider than the pointers, so that a distance of two fits at any depth.
    assign span = {1'b0, r_hi} - {1'b0, r_lo};

    // Status towards the controller.
    always_comb begin
        o_stat.full      = (r_count == CW'(DEPTH));
        o_stat.empty     = (r_count == '0);
        o_stat.single    = (r_count == CW'(1));
        o_stat.mismatch  = (r_rd_a != r_rd_b);
        o_stat.last_pair = (span <= (AW+1)'(2));
    end

    // Result registers; the strobe lasts one cycle.
    assign fill_ext = {8'b0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_dp_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.emit) begin
            r_status <= i_dp_cmd.res_status;
            r_popped <= i_dp_cmd.res_use_rd ? r_rd_b : 32'd0;
            r_pal    <= i_dp_cmd.res_pal;
            r_fill   <= fill_ext[7:0];
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_popped_value  = r_popped;
    assign o_is_palindrome = r_pal;
    assign o_fill_count    = r_fill;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for stack_with_palindrome_check.
// Sends push, pop and palindrome-check items, predicts each result with a local stack model
// and compares it field by field; depends on stkpal_pkg and the design sources.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stkpal_pkg::*;

    localparam int DEPTH = 128;
    localparam logic [1:0] CMD_NOP = 2'd3;      // unused command code, does nothing
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int GAP_MAX = 24;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] popped;
        logic               pal;
        logic [7:0]         fill;
    } t_stack_result;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         i_cmd = CMD_NOP;
    logic signed [31:0] i_push_value = '0;
    logic               busy;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_popped_value;
    logic               o_is_palindrome;
    logic [7:0]         o_fill_count;

    // Model of the stack contents and the results still owed by the block.
    logic signed [31:0] model_words [DEPTH];
    int                 model_fill = 0;
    t_stack_result      pending_results [$];
    int                 items_sent = 0;
    int                 err_count = 0;
    int                 cycle_count = 0;
    int                 idle_pct = 0;
    int                 burst_left = 0;

    stack_with_palindrome_check #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(i_cmd),
        .i_push_value(i_push_value),
        .o_valid(o_valid),
        .o_status(o_status),
        .o_popped_value(o_popped_value),
        .o_is_palindrome(o_is_palindrome),
        .o_fill_count(o_fill_count)
    );

    // Free-running clock, 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Applies one operation to the model stack and returns the result it gives.
    function automatic t_stack_result apply_stack_op(input logic [1:0] cmd,
                                                     input logic signed [31:0] word);
        t_stack_result r;
        int lo;
        int hi;
        r.status = ST_OK;
        r.popped = '0;
        r.pal = 1'b0;
        case (cmd)
            CMD_PUSH: begin
                if (model_fill >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    model_words[model_fill] = word;
                    model_fill++;
                end
            end
            CMD_POP: begin
                if (model_fill == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    model_fill--;
                    r.popped = model_words[model_fill];
                end
            end
            CMD_CHECK: begin
                if (model_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // Walk inward from both ends; a single entry reads the same both ways.
                    r.pal = 1'b1;
                    lo = 0;
                    hi = model_fill - 1;
                    while (lo < hi) begin
                        if (model_words[lo] != model_words[hi]) r.pal = 1'b0;
                        lo++;
                        hi--;
                    end
                end
            end
            default: ;
        endcase
        r.fill = 8'(model_fill);
        return r;
    endfunction

    // Word source weighted towards the extremes and small values, so equal pairs occur.
    function automatic logic signed [31:0] rand_word();
        int pick;
        pick = $urandom_range(7);
        if (pick < 4) return $urandom;
        if (pick == 4) return $urandom_range(15);
        if (pick == 5) return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        if (pick == 6) return $urandom_range(1) ? 32'sd0 : -32'sd1;
        return $urandom_range(3);
    endfunction

    // Holds the sender back for a while, with occasional stretches of back-to-back items.
    task automatic pause_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        if ($urandom_range(99) < 3) begin
            burst_left = $urandom_range(40, 10);
            return;
        end
        if (idle_pct == 0 || $urandom_range(99) >= idle_pct) return;
        // Idle inputs carry noise, which the block must ignore while start is low.
        start <= 1'b0;
        i_cmd <= 2'($urandom);
        i_push_value <= $urandom;
        gap = 1;
        @(posedge i_clk);
        while (gap < GAP_MAX && $urandom_range(99) < idle_pct) begin
            @(posedge i_clk);
            gap++;
        end
    endtask

    // Offers one item, waits until the block takes it, and records the result it owes.
    task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] word);
        start <= 1'b1;
        i_cmd <= cmd;
        i_push_value <= word;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_results.push_back(apply_stack_op(cmd, word));
        items_sent++;
        pause_sender();
    endtask

    // Empty-stack errors, a single entry, odd and even palindromes and the word extremes.
    task automatic test_corner_cases();
        idle_pct = 0;
        send_item(CMD_POP, 32'sh7FFF_FFFF);
        send_item(CMD_CHECK, -32'sd1);
        send_item(CMD_NOP, 32'sh8000_0000);
        send_item(CMD_PUSH, 32'sh7FFF_FFFF);
        send_item(CMD_CHECK, 32'sd0);
        send_item(CMD_NOP, -32'sd1);
        send_item(CMD_PUSH, 32'sh8000_0000);
        send_item(CMD_CHECK, 32'sd0);
        send_item(CMD_PUSH, 32'sh7FFF_FFFF);
        send_item(CMD_CHECK, 32'sd0);
        repeat (3) send_item(CMD_POP, -32'sd1);
        send_item(CMD_POP, 32'sd0);
        send_item(CMD_PUSH, 32'sd0);
        send_item(CMD_PUSH, -32'sd1);
        send_item(CMD_PUSH, -32'sd1);
        send_item(CMD_PUSH, 32'sd0);
        send_item(CMD_CHECK, 32'sh8000_0000);
        send_item(CMD_PUSH, 32'sd0);
        send_item(CMD_CHECK, 32'sd0);
        repeat (5) send_item(CMD_POP, 32'sd0);
        send_item(CMD_CHECK, 32'sd0);
    endtask

    // Builds mirrored contents, sometimes with one corrupted word, and checks them.
    task automatic test_mirrored_contents();
        logic signed [31:0] half [$];
        int                 len;
        int                 bad_pos;
        logic               has_middle;
        if ($urandom_range(3) != 0) begin
            while (model_fill > 0) send_item(CMD_POP, $urandom);
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 7) : $urandom_range(6, 0);
        has_middle = 1'($urandom_range(1));
        bad_pos = ($urandom_range(9) < 3) ? $urandom_range(len) : -1;
        for (int k = 0; k < len; k++) begin
            half.push_back(rand_word());
            send_item(CMD_PUSH, half[k]);
        end
        if (has_middle) send_item(CMD_PUSH, rand_word());
        for (int k = len - 1; k >= 0; k--) begin
            if (k == bad_pos) begin
                send_item(CMD_PUSH, half[k] ^ (32'd1 << $urandom_range(31)));
            end else begin
                send_item(CMD_PUSH, half[k]);
            end
        end
        send_item(CMD_CHECK, $urandom);
        // Shrinking the contents changes which pairs are compared.
        repeat ($urandom_range(3)) begin
            send_item(CMD_POP, $urandom);
            send_item(CMD_CHECK, $urandom);
        end
    endtask

    // Fills the stack to the brim with mirrored words, then overflows it.
    task automatic test_full_stack();
        logic signed [31:0] half [$];
        int                 keep;
        while (model_fill > 0) send_item(CMD_POP, $urandom);
        for (int k = 0; k < DEPTH / 2; k++) begin
            half.push_back(rand_word());
            send_item(CMD_PUSH, half[k]);
        end
        for (int k = DEPTH / 2 - 1; k >= 0; k--) send_item(CMD_PUSH, half[k]);
        send_item(CMD_CHECK, $urandom);
        repeat ($urandom_range(3, 1)) send_item(CMD_PUSH, rand_word());
        send_item(CMD_NOP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_PUSH, rand_word());
        send_item(CMD_CHECK, $urandom);
        send_item(CMD_PUSH, rand_word());
        keep = $urandom_range(DEPTH);
        while (model_fill > keep) send_item(CMD_POP, $urandom);
    endtask

    // Unordered mix of every command code.
    task automatic test_mixed_traffic();
        int         r;
        logic [1:0] cmd;
        repeat ($urandom_range(40, 10)) begin
            r = $urandom_range(99);
            if (r < 10) cmd = CMD_NOP;
            else if (r < 28) cmd = CMD_CHECK;
            else if (r < 64) cmd = CMD_PUSH;
            else cmd = CMD_POP;
            send_item(cmd, (cmd == CMD_PUSH) ? rand_word() : 32'($urandom));
        end
    endtask

    // Compares each result with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_stack_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d popped %0d pal %0d fill %0d",
                         $time, o_status, o_popped_value, o_is_palindrome, o_fill_count);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, o_status);
                    err_count++;
                end
                if (o_popped_value !== want.popped) begin
                    $display("%0t: popped value expected %0d, got %0d",
                             $time, want.popped, o_popped_value);
                    err_count++;
                end
                if (o_is_palindrome !== want.pal) begin
                    $display("%0t: palindrome flag expected %0d, got %0d",
                             $time, want.pal, o_is_palindrome);
                    err_count++;
                end
                if (o_fill_count !== want.fill) begin
                    $display("%0t: fill count expected %0d, got %0d",
                             $time, want.fill, o_fill_count);
                    err_count++;
                end
            end
        end
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Reset, directed items, then random traffic under three sender idling rates.
    initial begin
        int idle_rates [3];
        int quotas [3];
        idle_rates = '{0, 84, 16};
        quotas = '{550, 1050, 1550};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_cases();
        for (int p = 0; p < 3; p++) begin
            idle_pct = idle_rates[p];
            burst_left = 0;
            test_full_stack();
            while (items_sent < quotas[p]) begin
                if ($urandom_range(99) < 55) test_mirrored_contents();
                else test_mixed_traffic();
            end
        end
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
